// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros included by the controller design file
// Concurrent checks clocked on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/ktsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ktsc_pkg
// Codes, digit types, digit tables and the state struct of the keypad timer/stopwatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ktsc_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned DigitW     = 4;

  typedef logic [DigitW-1:0] digit_t;
  // Index 0 is the leftmost digit (tens of minutes)
  typedef digit_t [DigitCount-1:0] digits_t;

  localparam digit_t BLANK_CODE = 4'd10;

  // Key codes
  localparam logic [3:0] KEY_OK     = 4'd10;
  localparam logic [3:0] KEY_DELETE = 4'd11;
  localparam logic [3:0] KEY_MODE   = 4'd12;

  // Item kinds
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Mode codes
  localparam logic [1:0] MODE_ENTRY     = 2'd0;
  localparam logic [1:0] MODE_TIMER     = 2'd1;
  localparam logic [1:0] MODE_STOPWATCH = 2'd2;

  // Stopwatch wrap limits and timer borrow reloads, listed from the rightmost digit
  localparam digits_t SW_LIMIT  = {4'd10, 4'd6, 4'd10, 4'd6};
  localparam digits_t TM_RELOAD = {4'd9, 4'd5, 4'd9, 4'd9};

  typedef struct packed {
    digits_t    entry;
    digits_t    count;
    logic [1:0] mode;
    logic       run;
  } ctrl_state_t;

endpackage

// ===== design/ktsc_update.sv =====
// ----------------------------------------------------------------------------
// ktsc_update
// Next-state logic for one key press or one-second tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktsc_update (
  input  ktsc_pkg::ctrl_state_t state_i,
  input  logic                  opcode_i,
  input  logic [3:0]            key_code_i,
  output ktsc_pkg::ctrl_state_t state_o,
  output logic                  alarm_o
);

  ktsc_pkg::digits_t sw_next;
  ktsc_pkg::digits_t tm_next;
  logic              sw_carry;
  logic              tm_borrow;
  logic [4:0]        sw_sum;

  // Advance the stopwatch: ripple a carry from the seconds digit leftward
  always_comb begin
    sw_carry = 1'b1;
    sw_sum   = '0;
    sw_next  = state_i.count;
    for (int i = ktsc_pkg::DigitCount - 1; i >= 0; i--) begin
      if (sw_carry) begin
        sw_sum = {1'b0, state_i.count[i]} + 5'd1;
        if (sw_sum < {1'b0, ktsc_pkg::SW_LIMIT[i]}) begin
          sw_next[i] = sw_sum[3:0];
          sw_carry   = 1'b0;
        end else begin
          sw_next[i] = '0;
        end
      end
    end
  end

  // Count the timer down: zero digits reload while the borrow ripples left
  always_comb begin
    tm_borrow = 1'b1;
    tm_next   = state_i.count;
    for (int i = ktsc_pkg::DigitCount - 1; i >= 0; i--) begin
      if (tm_borrow) begin
        if (state_i.count[i] != '0) begin
          tm_next[i] = state_i.count[i] - 4'd1;
          tm_borrow  = 1'b0;
        end else begin
          tm_next[i] = ktsc_pkg::TM_RELOAD[i];
        end
      end
    end
  end

  // Apply the transaction to the state
  always_comb begin
    state_o = state_i;
    alarm_o = 1'b0;
    if (opcode_i == ktsc_pkg::OP_KEY) begin
      if (state_i.mode == ktsc_pkg::MODE_ENTRY) begin
        if (key_code_i inside {[4'd0:4'd9]}) begin
          if (state_i.entry[0] == ktsc_pkg::BLANK_CODE) begin
            for (int i = 0; i < ktsc_pkg::DigitCount - 1; i++) begin
              state_o.entry[i] = state_i.entry[i+1];
            end
            state_o.entry[ktsc_pkg::DigitCount-1] = key_code_i;
          end
        end else begin
          case (key_code_i)
            ktsc_pkg::KEY_DELETE: begin
              for (int i = ktsc_pkg::DigitCount - 1; i > 0; i--) begin
                state_o.entry[i] = state_i.entry[i-1];
              end
              state_o.entry[0] = ktsc_pkg::BLANK_CODE;
            end
            ktsc_pkg::KEY_OK: begin
              for (int i = 0; i < ktsc_pkg::DigitCount; i++) begin
                state_o.count[i] = (state_i.entry[i] == ktsc_pkg::BLANK_CODE) ?
                                   '0 : state_i.entry[i];
              end
              state_o.mode = ktsc_pkg::MODE_TIMER;
              state_o.run  = 1'b1;
            end
            ktsc_pkg::KEY_MODE: begin
              state_o.count = '0;
              state_o.mode  = ktsc_pkg::MODE_STOPWATCH;
              state_o.run   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end else if (state_i.run) begin
        if (key_code_i == ktsc_pkg::KEY_OK) begin
          state_o.run = 1'b0;
        end
      end else begin
        if (key_code_i == ktsc_pkg::KEY_OK) begin
          state_o.run = 1'b1;
        end else if (key_code_i == ktsc_pkg::KEY_MODE) begin
          state_o.entry = {ktsc_pkg::DigitCount{ktsc_pkg::BLANK_CODE}};
          state_o.mode  = ktsc_pkg::MODE_ENTRY;
        end
      end
    end else if (state_i.run) begin
      if (state_i.mode == ktsc_pkg::MODE_STOPWATCH) begin
        state_o.count = sw_next;
      end else if (state_i.mode == ktsc_pkg::MODE_TIMER) begin
        if (tm_borrow) begin
          // Expired at 00:00: hold the count, drop back to a blank entry
          alarm_o       = 1'b1;
          state_o.mode  = ktsc_pkg::MODE_ENTRY;
          state_o.run   = 1'b0;
          state_o.entry = {ktsc_pkg::DigitCount{ktsc_pkg::BLANK_CODE}};
        end else begin
          state_o.count = tm_next;
        end
      end
    end
  end

endmodule

// ===== design/keypad_timer_stopwatch_controller.sv =====
// ----------------------------------------------------------------------------
// keypad_timer_stopwatch_controller
// mm:ss countdown timer and stopwatch driven by key presses and second ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one transaction per event:
//   opcode_i 0 is a key press with key_code_i, opcode_i 1 a one-second tick.
//   Output channel (out_valid_o/out_ready_i) returns exactly one transaction
//   per input: four shown digits (10 = blank), mode, run flag and alarm.
//   The event lands in an input register, the state update runs in one pass
//   of logic, and the result lands in the output register. Throughput is one
//   transaction per cycle while out_ready_i stays high, set by that single
//   update pass and the one-deep input register.
//   When the receiver stalls, the result is held and one more event waits in
//   the input register; in_ready_o drops only when both are full.
//   Reset clears the entry buffer to blank, the count to 00:00, selects entry
//   mode, pauses, and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_timer_stopwatch_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [3:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] shown_digit_0_o,
  output logic [3:0] shown_digit_1_o,
  output logic [3:0] shown_digit_2_o,
  output logic [3:0] shown_digit_3_o,
  output logic [1:0] current_mode_o,
  output logic       is_running_o,
  output logic       alarm_o
);

  ktsc_pkg::ctrl_state_t state_q, state_d;
  logic                  in_valid_q;
  logic                  opcode_q;
  logic [3:0]            key_q;
  logic                  advance;
  logic                  alarm_d;

  ktsc_pkg::digits_t     shown_q;
  logic [1:0]            mode_out_q;
  logic                  run_out_q;
  logic                  alarm_q;
  logic                  out_valid_q;

  // Move the held event into the result register when it is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      opcode_q <= opcode_i;
      key_q    <= key_code_i;
    end
  end

  ktsc_update u_update (
    .state_i    (state_q),
    .opcode_i   (opcode_q),
    .key_code_i (key_q),
    .state_o    (state_d),
    .alarm_o    (alarm_d)
  );

  // Commit the state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.entry <= {ktsc_pkg::DigitCount{ktsc_pkg::BLANK_CODE}};
      state_q.count <= '0;
      state_q.mode  <= ktsc_pkg::MODE_ENTRY;
      state_q.run   <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      shown_q    <= (state_d.mode == ktsc_pkg::MODE_ENTRY) ? state_d.entry : state_d.count;
      mode_out_q <= state_d.mode;
      run_out_q  <= state_d.run;
      alarm_q    <= alarm_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shown_digit_0_o = shown_q[0];
  assign shown_digit_1_o = shown_q[1];
  assign shown_digit_2_o = shown_q[2];
  assign shown_digit_3_o = shown_q[3];
  assign current_mode_o  = mode_out_q;
  assign is_running_o    = run_out_q;
  assign alarm_o         = alarm_q;

  // Checks
  `ASSERT_CHK(a_alarm_ends_count, out_valid_o && alarm_o |-> current_mode_o == ktsc_pkg::MODE_ENTRY && !is_running_o, "alarm result not in paused entry mode")
  `ASSERT_ALWAYS(a_stall_only_full, !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i, "input stalled without a full pipeline")
  `ASSERT_CHK(a_state_holds, !advance |=> $stable(state_q), "state changed without a transaction")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad timer/stopwatch: a table of directed key
// presses and ticks, a stopwatch run across a minute boundary, then state-aware
// random sequences. Each shown result is checked against a clock-face predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RAND_ITEMS     = 550;
  localparam int unsigned SWEEP_TICKS    = 70;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Key codes the block must ignore
  localparam logic [3:0] KEY_DECODE_ERR = 4'd13;
  localparam logic [3:0] KEY_SPARE_LO   = 4'd14;
  localparam logic [3:0] KEY_SPARE_HI   = 4'd15;

  localparam ktsc_pkg::digits_t ALL_BLANK = {ktsc_pkg::DigitCount{ktsc_pkg::BLANK_CODE}};
  localparam ktsc_pkg::digits_t ALL_ZERO  = '0;

  typedef struct packed {
    ktsc_pkg::digits_t digits;
    logic [1:0]        mode;
    logic              run;
    logic              alarm;
  } face_t;

  typedef struct {
    logic       op;
    logic [3:0] key;
    bit         typed;
    face_t      want;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       opcode      = 1'b0;
  logic [3:0] key_code    = 4'd0;
  logic       out_ready   = 1'b0;
  logic       quiet       = 1'b0;
  logic       hold_go     = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] shown_digit_0_o;
  logic [3:0] shown_digit_1_o;
  logic [3:0] shown_digit_2_o;
  logic [3:0] shown_digit_3_o;
  logic [1:0] current_mode_o;
  logic       is_running_o;
  logic       alarm_o;

  // Shadow state of the clock face
  ktsc_pkg::digits_t sh_entry = ALL_BLANK;
  ktsc_pkg::digits_t sh_count = ALL_ZERO;
  logic [1:0]        sh_mode  = ktsc_pkg::MODE_ENTRY;
  logic              sh_run   = 1'b0;

  face_t       face_q[$];
  row_t        row_q[$];
  int unsigned err_count = 0;

  keypad_timer_stopwatch_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode),
    .key_code_i      (key_code),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .shown_digit_0_o (shown_digit_0_o),
    .shown_digit_1_o (shown_digit_1_o),
    .shown_digit_2_o (shown_digit_2_o),
    .shown_digit_3_o (shown_digit_3_o),
    .current_mode_o  (current_mode_o),
    .is_running_o    (is_running_o),
    .alarm_o         (alarm_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the shadow state by one event and return the face it shows
  function automatic face_t next_face(logic op, logic [3:0] key);
    face_t r;
    logic  fired;
    bit    done;
    int    i;
    int    j;
    fired = 1'b0;
    done  = 1'b0;
    if (op == ktsc_pkg::OP_KEY) begin
      if (sh_mode == ktsc_pkg::MODE_ENTRY) begin
        if (key <= 4'd9) begin
          // shift a digit in from the right unless the buffer is full
          if (sh_entry[0] == ktsc_pkg::BLANK_CODE) begin
            for (i = 0; i < ktsc_pkg::DigitCount - 1; i++) sh_entry[i] = sh_entry[i+1];
            sh_entry[ktsc_pkg::DigitCount-1] = key;
          end
        end else if (key == ktsc_pkg::KEY_DELETE) begin
          for (i = ktsc_pkg::DigitCount - 1; i > 0; i--) sh_entry[i] = sh_entry[i-1];
          sh_entry[0] = ktsc_pkg::BLANK_CODE;
        end else if (key == ktsc_pkg::KEY_OK) begin
          for (i = 0; i < ktsc_pkg::DigitCount; i++)
            sh_count[i] = (sh_entry[i] == ktsc_pkg::BLANK_CODE) ? 4'd0 : sh_entry[i];
          sh_mode = ktsc_pkg::MODE_TIMER;
          sh_run  = 1'b1;
        end else if (key == ktsc_pkg::KEY_MODE) begin
          sh_count = ALL_ZERO;
          sh_mode  = ktsc_pkg::MODE_STOPWATCH;
          sh_run   = 1'b1;
        end
      end else if (sh_run) begin
        if (key == ktsc_pkg::KEY_OK) sh_run = 1'b0;
      end else begin
        if (key == ktsc_pkg::KEY_OK) begin
          sh_run = 1'b1;
        end else if (key == ktsc_pkg::KEY_MODE) begin
          sh_entry = ALL_BLANK;
          sh_mode  = ktsc_pkg::MODE_ENTRY;
        end
      end
    end else if (sh_run) begin
      if (sh_mode == ktsc_pkg::MODE_STOPWATCH) begin
        // count up: seconds wrap at 10, tens places at 6
        for (i = ktsc_pkg::DigitCount - 1; i >= 0 && !done; i--) begin
          if (int'(sh_count[i]) + 1 < ((i % 2 == 1) ? 10 : 6)) begin
            sh_count[i] = sh_count[i] + 4'd1;
            done = 1'b1;
          end else begin
            sh_count[i] = 4'd0;
          end
        end
      end else if (sh_mode == ktsc_pkg::MODE_TIMER) begin
        // count down, borrowing 9 into units and 5 into tens of seconds
        for (i = ktsc_pkg::DigitCount - 1; i >= 0 && !done; i--) begin
          if (sh_count[i] != 4'd0) begin
            sh_count[i] = sh_count[i] - 4'd1;
            for (j = i + 1; j < ktsc_pkg::DigitCount; j++)
              sh_count[j] = (j == 2) ? 4'd5 : 4'd9;
            done = 1'b1;
          end
        end
        if (!done) begin
          fired    = 1'b1;
          sh_mode  = ktsc_pkg::MODE_ENTRY;
          sh_run   = 1'b0;
          sh_entry = ALL_BLANK;
        end
      end
    end
    r.digits = (sh_mode == ktsc_pkg::MODE_ENTRY) ? sh_entry : sh_count;
    r.mode   = sh_mode;
    r.run    = sh_run;
    r.alarm  = fired;
    return r;
  endfunction

  // Pick a random event that mostly follows a sensible use of the keypad
  function automatic void pick_event(output logic op, output logic [3:0] key);
    int unsigned r;
    int unsigned filled;
    int unsigned digit_thr;
    bit          big;
    int          i;
    r      = $urandom_range(0, 99);
    filled = 0;
    for (i = 0; i < ktsc_pkg::DigitCount; i++)
      if (sh_entry[i] != ktsc_pkg::BLANK_CODE) filled++;
    big = (sh_count[0] != 4'd0) || (sh_count[1] != 4'd0);
    op  = ktsc_pkg::OP_KEY;
    key = 4'($urandom_range(0, 9));
    if (sh_mode == ktsc_pkg::MODE_ENTRY) begin
      digit_thr = (filled < 2) ? 70 : 40;
      if (r < 6)                key = 4'($urandom_range(13, 15));
      else if (r < 12)          op  = ktsc_pkg::OP_TICK;
      else if (r < 20)          key = ktsc_pkg::KEY_DELETE;
      else if (r < digit_thr)   key = 4'($urandom_range(0, 9));
      else if (r < 90)          key = ktsc_pkg::KEY_OK;
      else                      key = ktsc_pkg::KEY_MODE;
    end else if (sh_run) begin
      if ((big || sh_mode == ktsc_pkg::MODE_STOPWATCH) && r < 10) key = ktsc_pkg::KEY_OK;
      else if (r < 78)          op  = ktsc_pkg::OP_TICK;
      else if (r < 84)          key = ktsc_pkg::KEY_OK;
      else if (r < 88)          key = 4'($urandom_range(0, 9));
      else if (r < 92)          key = ktsc_pkg::KEY_DELETE;
      else if (r < 96)          key = ktsc_pkg::KEY_MODE;
      else                      key = 4'($urandom_range(13, 15));
    end else begin
      if (r < 45)               key = ktsc_pkg::KEY_MODE;
      else if (r < 70)          key = ktsc_pkg::KEY_OK;
      else if (r < 85)          op  = ktsc_pkg::OP_TICK;
      else                      key = 4'($urandom_range(0, 15));
    end
  endfunction

  function automatic void add_row(logic op, logic [3:0] key, bit typed = 1'b0,
                                  face_t want = '0);
    row_t row;
    row.op    = op;
    row.key   = key;
    row.typed = typed;
    row.want  = want;
    row_q.push_back(row);
  endfunction

  // Offer one transaction, wait for acceptance, then record the expected face
  task automatic offer(logic op, logic [3:0] key, bit typed, face_t want);
    face_t got;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_code <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = next_face(op, key);
    face_q.push_back(typed ? want : got);
  endtask

  // Hold the sender off until every expected face has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (face_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin : stimulus
    logic       op;
    logic [3:0] key;
    int unsigned n;
    face_t      none;
    none = '0;

    add_row(ktsc_pkg::OP_TICK, 4'd0, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b0});
    add_row(ktsc_pkg::OP_KEY, KEY_DECODE_ERR, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b0});
    add_row(ktsc_pkg::OP_KEY, KEY_SPARE_LO, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b0});
    add_row(ktsc_pkg::OP_KEY, KEY_SPARE_HI, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b0});
    add_row(ktsc_pkg::OP_KEY, ktsc_pkg::KEY_DELETE, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b0});
    add_row(ktsc_pkg::OP_KEY, ktsc_pkg::KEY_OK, 1'b1,
            '{ALL_ZERO, ktsc_pkg::MODE_TIMER, 1'b1, 1'b0});
    add_row(ktsc_pkg::OP_TICK, 4'd0, 1'b1,
            '{ALL_BLANK, ktsc_pkg::MODE_ENTRY, 1'b0, 1'b1});
    // fill the buffer with a tens digit above five, overflow it, delete, refill, start and tick
    add_row(ktsc_pkg::OP_KEY,  4'd9);
    add_row(ktsc_pkg::OP_KEY,  4'd0);
    add_row(ktsc_pkg::OP_KEY,  4'd5);
    add_row(ktsc_pkg::OP_KEY,  4'd9);
    add_row(ktsc_pkg::OP_KEY,  4'd3);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_DELETE);
    add_row(ktsc_pkg::OP_KEY,  4'd9);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_OK);
    add_row(ktsc_pkg::OP_TICK, 4'd0);
    // keys ignored while counting
    add_row(ktsc_pkg::OP_KEY,  4'd4);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_DELETE);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_MODE);
    // pause, tick while paused, resume, tick, pause, leave, start the stopwatch
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_OK);
    add_row(ktsc_pkg::OP_TICK, 4'd0);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_OK);
    add_row(ktsc_pkg::OP_TICK, 4'd0);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_OK);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_MODE);
    add_row(ktsc_pkg::OP_KEY,  ktsc_pkg::KEY_MODE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (row_q[i]) offer(row_q[i].op, row_q[i].key, row_q[i].typed, row_q[i].want);

    // run the stopwatch past a minute boundary and leave it
    for (n = 0; n < SWEEP_TICKS; n++) offer(ktsc_pkg::OP_TICK, 4'd0, 1'b0, none);
    offer(ktsc_pkg::OP_KEY, ktsc_pkg::KEY_OK, 1'b0, none);
    offer(ktsc_pkg::OP_KEY, ktsc_pkg::KEY_MODE, 1'b0, none);
    drain();

    for (n = 0; n < RAND_ITEMS; n++) begin
      quiet <= (n >= RAND_ITEMS - 100) || (n >= 250 && n < 320);
      if (n == 150) hold_go <= 1'b1;
      if (n == 420) drain();
      pick_event(op, key);
      offer(op, key, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (face_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    err_count += face_q.size();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Check each accepted face and drive the receiver's ready
  always @(posedge clk_i) begin : receiver
    static int unsigned hold_left = 0;
    static int unsigned gap_left  = 0;
    static bit          hold_done = 1'b0;
    face_t want;
    face_t seen;
    if (out_valid_o && out_ready) begin
      seen.digits[0] = shown_digit_0_o;
      seen.digits[1] = shown_digit_1_o;
      seen.digits[2] = shown_digit_2_o;
      seen.digits[3] = shown_digit_3_o;
      seen.mode      = current_mode_o;
      seen.run       = is_running_o;
      seen.alarm     = alarm_o;
      if (face_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected: got %0d %0d %0d %0d m%0d r%0d a%0d",
                   seen.digits[0], seen.digits[1], seen.digits[2], seen.digits[3],
                   seen.mode, seen.run, seen.alarm);
      end else begin
        want = face_q.pop_front();
        if (seen.digits !== want.digits || seen.mode !== want.mode ||
            seen.run !== want.run || seen.alarm !== want.alarm) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"mismatch: want %0d %0d %0d %0d m%0d r%0d a%0d,",
                      " got %0d %0d %0d %0d m%0d r%0d a%0d"},
                     want.digits[0], want.digits[1], want.digits[2], want.digits[3],
                     want.mode, want.run, want.alarm,
                     seen.digits[0], seen.digits[1], seen.digits[2], seen.digits[3],
                     seen.mode, seen.run, seen.alarm);
        end
      end
    end
    // one long hold-off once hold_go is set, otherwise random stall bursts
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 12) begin
      gap_left  = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
